// File: design/upd_pkg.sv
package upd_pkg;

	localparam int UPD_FIFO_DEPTH  = 4;
	localparam int UPD_GROUP_BYTES = 3;

	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_SPACE   = 8'h20;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'b001,
		PH_PCT   = 3'b010,
		PH_DIGIT = 3'b100
	} esc_phase_t;

	// Bytes that one request produces, oldest in data[0].
	typedef struct packed {
		logic [1:0]                      cnt;
		logic [UPD_GROUP_BYTES-1:0][7:0] data;
		logic                            eos;
	} upd_group_t;

	typedef struct packed {
		logic       valid;
		logic [3:0] value;
	} hex_digit_t;

	function automatic hex_digit_t hex_decode(logic [7:0] c);
		hex_digit_t r;
		r.valid = 1'b0;
		r.value = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r.valid = 1'b1;
			r.value = c[3:0];
		end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
			r.valid = 1'b1;
			r.value = c[3:0] + 4'd9;
		end
		return r;
	endfunction

endpackage

// File: design/url_percent_decoder.sv
// Path: the first decoded byte of a request is written into the group queue by the edge that
// accepted it and is then loaded into the output register, which the result side can stall.
// Throughput: one request per cycle while each yields at most one byte and the queue is not full;
// a request that yields two or three bytes goes out of the single output register one byte at a time.
// Reset (arst_n low) clears the escape state, the group queue and the output valid flag.
module url_percent_decoder #(
	parameter int FIFO_DEPTH = upd_pkg::UPD_FIFO_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] in_byte,
	input  logic       end_of_string,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_byte,
	output logic       out_last
);
	import upd_pkg::*;

	upd_group_t f_grp, q_grp;
	logic       f_valid;
	logic       take;
	logic       q_empty;
	logic       q_rd;

	assign take = push && !full;

	upd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.in_byte      (in_byte),
		.end_of_string(end_of_string),
		.grp          (f_grp),
		.grp_valid    (f_valid)
	);

	upd_fifo #(
		.DEPTH(FIFO_DEPTH)
	) u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (take && f_valid),
		.wdata (f_grp),
		.rd    (q_rd),
		.rdata (q_grp),
		.full  (full),
		.empty (q_empty)
	);

	upd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.grp      (q_grp),
		.grp_valid(!q_empty),
		.grp_take (q_rd),
		.pop      (pop),
		.empty    (empty),
		.out_byte (out_byte),
		.out_last (out_last)
	);

endmodule

// File: design/upd_front.sv
module upd_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               take,
	input  logic [7:0]         in_byte,
	input  logic               end_of_string,
	output upd_pkg::upd_group_t grp,
	output logic               grp_valid
);
	import upd_pkg::*;

	esc_phase_t phase_q, nph;
	logic [7:0] held_q, nheld;
	logic [7:0] res [4];
	logic [1:0] n;
	logic       do_plain;
	logic       plain_open;
	logic [7:0] plain_byte;
	hex_digit_t cur_hex, held_hex;

	assign cur_hex    = hex_decode(in_byte);
	assign held_hex   = hex_decode(held_q);
	assign plain_open = (in_byte == CH_PERCENT);
	assign plain_byte = (in_byte == CH_PLUS) ? CH_SPACE : in_byte;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			res[i] = '0;
		end
		n        = 2'd0;
		nph      = PH_IDLE;
		nheld    = held_q;
		do_plain = 1'b0;

		case (phase_q)
			PH_PCT: begin
				if (cur_hex.valid) begin
					nheld = in_byte;
					nph   = PH_DIGIT;
				end else begin
					res[0]   = CH_PERCENT;
					n        = 2'd1;
					do_plain = 1'b1;
				end
			end
			PH_DIGIT: begin
				nheld = '0;
				if (cur_hex.valid) begin
					res[0] = {held_hex.value, cur_hex.value};
					n      = 2'd1;
				end else begin
					res[0]   = CH_PERCENT;
					res[1]   = held_q;
					n        = 2'd2;
					do_plain = 1'b1;
				end
			end
			default: begin
				do_plain = 1'b1;
			end
		endcase

		// The byte that broke an escape is decoded as if no escape had been open.
		if (do_plain) begin
			if (plain_open) begin
				nph = PH_PCT;
			end else begin
				res[n] = plain_byte;
				n      = n + 2'd1;
			end
		end

		// A pending escape is flushed literally at the end of the string.
		if (end_of_string) begin
			if (nph == PH_PCT) begin
				res[n] = CH_PERCENT;
				n      = n + 2'd1;
			end else if (nph == PH_DIGIT) begin
				res[n]        = CH_PERCENT;
				res[n + 2'd1] = nheld;
				n             = n + 2'd2;
			end
			nph   = PH_IDLE;
			nheld = '0;
		end
	end

	always_comb begin
		for (int i = 0; i < UPD_GROUP_BYTES; i++) begin
			grp.data[i] = res[i];
		end
		grp.cnt = n;
		grp.eos = end_of_string;
	end

	assign grp_valid = (n != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			held_q  <= '0;
		end else if (take) begin
			phase_q <= nph;
			held_q  <= nheld;
		end
	end

endmodule

// File: design/upd_fifo.sv
module upd_fifo #(
	parameter int DEPTH = upd_pkg::UPD_FIFO_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr,
	input  upd_pkg::upd_group_t wdata,
	input  logic                rd,
	output upd_pkg::upd_group_t rdata,
	output logic                full,
	output logic                empty
);
	import upd_pkg::*;

	// DEPTH must be at least two.
	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	upd_group_t    mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_wr, do_rd;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// File: design/upd_back.sv
module upd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  upd_pkg::upd_group_t grp,
	input  logic                grp_valid,
	output logic                grp_take,
	input  logic                pop,
	output logic                empty,
	output logic [7:0]          out_byte,
	output logic                out_last
);
	import upd_pkg::*;

	logic [1:0] idx_q;
	logic       ovalid_q;
	logic [7:0] obyte_q;
	logic       olast_q;
	logic       load;
	logic       last_of_grp;

	assign load        = grp_valid && (!ovalid_q || pop);
	assign last_of_grp = (idx_q == grp.cnt - 2'd1);
	assign grp_take    = load && last_of_grp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
			idx_q    <= '0;
		end else begin
			if (load) begin
				ovalid_q <= 1'b1;
				idx_q    <= last_of_grp ? 2'd0 : idx_q + 2'd1;
			end else if (pop) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			obyte_q <= grp.data[idx_q];
			olast_q <= grp.eos && last_of_grp;
		end
	end

	assign empty    = !ovalid_q;
	assign out_byte = obyte_q;
	assign out_last = olast_q;

endmodule

// File: design/upd_checker.sv
module upd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       push,
	input logic       full,
	input logic       end_of_string,
	input logic       empty,
	input logic       pop,
	input logic [7:0] out_byte,
	input logic       out_last
);

	// Count of string ends accepted whose last byte has not yet been taken.
	logic [7:0] ends_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ends_q <= '0;
		end else begin
			case ({push && !full && end_of_string, pop && !empty && out_last})
				2'b10:   ends_q <= ends_q + 8'd1;
				2'b01:   ends_q <= ends_q - 8'd1;
				default: ends_q <= ends_q;
			endcase
		end
	end

	// Checked at the sample after the one that sees reset, so that the reset has surely reached every register.
	a_reset_empty: assert property (@(posedge clk) !arst_n |=> empty && !full)
		else $error("result side not empty or input side full during reset");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(out_byte) && $stable(out_last))
		else $error("waiting result changed before it was taken");

	a_last_owed: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && out_last |-> ends_q != 8'd0)
		else $error("end of string shown with no string end outstanding");

	a_no_end_no_last: assert property (@(posedge clk) disable iff (!arst_n)
		ends_q == 8'd0 && !(push && !full && end_of_string) |=> empty || !out_last)
		else $error("end of string shown before one was accepted");

endmodule

bind url_percent_decoder upd_checker u_upd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.push         (push),
	.full         (full),
	.end_of_string(end_of_string),
	.empty        (empty),
	.pop          (pop),
	.out_byte     (out_byte),
	.out_last     (out_last)
);
